### src/hncr_pkg.sv
// Shared types and codes for the height normalizer and color ramp.
package hncr_pkg;

  typedef enum logic [1:0] {
    OP_ACCUM = 2'd0,
    OP_MAP   = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b000_0001,
    ST_CLAMP     = 7'b000_0010,
    ST_LOAD_NUM  = 7'b000_0100,
    ST_DIV_LEVEL = 7'b000_1000,
    ST_RAMP      = 7'b001_0000,
    ST_LOAD_CHAN = 7'b010_0000,
    ST_DONE      = 7'b100_0000
  } state_e;

  typedef struct packed {
    logic take;
    logic clamp;
    logic load_num;
    logic div_step;
    logic ramp;
    logic load_chan;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_sts_t;

endpackage

### src/hncr_if.sv
// Valid/ready channel interfaces for height beats and color beats.
interface hncr_in_if #(
  parameter int HEIGHT_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    op;
  logic signed [HEIGHT_BITS-1:0] height;

  modport source (output valid, output op, output height, input ready);
  modport sink   (input valid, input op, input height, output ready);
endinterface

interface hncr_out_if #(
  parameter int LEVEL_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic [7:0]            red;
  logic [7:0]            green;
  logic [7:0]            blue;
  logic [LEVEL_BITS-1:0] level;
  logic                  flat_range;

  modport source (output valid, output red, output green, output blue, output level,
                  output flat_range, input ready);
  modport sink   (input valid, input red, input green, input blue, input level,
                  input flat_range, output ready);
endinterface

### src/hncr_ctrl.sv
// Sequencing state machine for the height normalizer and color ramp.
module hncr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [1:0]         in_op_i,
  output logic               in_ready_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  input  hncr_pkg::dp_sts_t  sts_i,
  output hncr_pkg::dp_cmd_t  cmd_o
);
  import hncr_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   take;
  logic   out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign take        = in_ready_o & in_valid_i;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.take = take;
    unique case (state_q)
      ST_IDLE: begin
        if (take && (in_op_i == OP_MAP)) state_d = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd_o.clamp = 1'b1;
        state_d = ST_LOAD_NUM;
      end
      ST_LOAD_NUM: begin
        cmd_o.load_num = 1'b1;
        state_d = ST_DIV_LEVEL;
      end
      ST_DIV_LEVEL: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = ST_RAMP;
      end
      ST_RAMP: begin
        cmd_o.ramp = 1'b1;
        state_d = ST_LOAD_CHAN;
      end
      ST_LOAD_CHAN: begin
        cmd_o.load_chan = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q & ~out_ready_i;
    if (cmd_o.load_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### src/hncr_dp.sv
// Extents tracker, restoring level divider and color ramp datapath.
module hncr_dp #(
  parameter int HEIGHT_BITS = 16,
  parameter int LEVEL_BITS  = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hncr_pkg::dp_cmd_t             cmd_i,
  output hncr_pkg::dp_sts_t             sts_o,
  input  logic [1:0]                    op_i,
  input  logic signed [HEIGHT_BITS-1:0] height_i,
  output logic [7:0]                    red_o,
  output logic [7:0]                    green_o,
  output logic [7:0]                    blue_o,
  output logic [LEVEL_BITS-1:0]         level_o,
  output logic                          flat_range_o
);
  import hncr_pkg::*;

  localparam int HB   = HEIGHT_BITS;
  localparam int LB   = LEVEL_BITS;
  localparam int QB   = (LB > 8) ? LB : 8;
  localparam int DNW  = (HB > LB) ? HB : LB;
  localparam int RW   = DNW + 1;
  localparam int WW   = RW + QB;
  localparam int CW   = $clog2(QB);
  localparam int L2   = LB + 2;
  localparam int CNW  = LB + 8;
  localparam int RSH  = CNW + LB;
  localparam int MW   = CNW + 1;
  localparam int PW   = CNW + MW;
  localparam longint FULL_L = (longint'(1) << LB) - 1;
  localparam logic [MW-1:0]  RECIP = MW'(((longint'(1) << RSH) + FULL_L - 1) / FULL_L);
  localparam logic [LB-1:0]  HALF  = LB'(((1 << LB) - 1) / 2);
  localparam logic [L2-1:0]  FULL1 = L2'((1 << LB) - 1);
  localparam logic [L2-1:0]  FULL2 = L2'(2 * ((1 << LB) - 1));
  localparam logic [L2-1:0]  FULL3 = L2'(3 * ((1 << LB) - 1));
  localparam logic [L2-1:0]  FULL4 = L2'(4 * ((1 << LB) - 1));

  typedef enum logic [1:0] {
    SEG_BLUE_CYAN    = 2'd0,
    SEG_CYAN_GREEN   = 2'd1,
    SEG_GREEN_YELLOW = 2'd2,
    SEG_YELLOW_RED   = 2'd3
  } seg_e;

  logic signed [HB-1:0] min_q, max_q, height_q, hc_q;
  logic                 empty_q;
  logic [DNW-1:0]       den_q;
  logic                 flat_q;
  logic [WW-1:0]        w_q, w_d;
  logic [CW-1:0]        cnt_q;
  logic [LB-1:0]        level_q, level_d;
  logic [LB-1:0]        n_q, n_d;
  seg_e                 seg_q, seg_d;
  logic [7:0]           chan_q;
  logic [7:0]           red_q, green_q, blue_q;
  logic [LB-1:0]        lvl_out_q;
  logic                 flat_out_q;

  logic signed [HB-1:0] hc_d;
  logic [HB:0]          den_full, num_full;
  logic [HB+LB-1:0]     prod;
  logic [CNW-1:0]       chan_num;
  logic [PW-1:0]        chan_prod;
  logic [PW-RSH-1:0]    chan_quot;
  logic [WW-1:0]        w_shift;
  logic [RW-1:0]        w_top;
  logic [RW-1:0]        den_ext;
  logic [L2-1:0]        l4;
  logic [QB-1:0]        quot;
  logic [7:0]           chan;

  // Extents
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q   <= '0;
      max_q   <= '0;
      empty_q <= 1'b1;
    end else if (cmd_i.take) begin
      if (op_i == OP_ACCUM) begin
        if (empty_q) begin
          min_q   <= height_i;
          max_q   <= height_i;
          empty_q <= 1'b0;
        end else begin
          if (height_i < min_q) min_q <= height_i;
          if (height_i > max_q) max_q <= height_i;
        end
      end else if (op_i == OP_CLEAR) begin
        min_q   <= '0;
        max_q   <= '0;
        empty_q <= 1'b1;
      end
    end
  end

  // Clamp and range
  always_comb begin
    priority if (height_q < min_q) hc_d = min_q;
    else if (height_q > max_q)     hc_d = max_q;
    else                           hc_d = height_q;
  end

  assign den_full = {max_q[HB-1], max_q} - {min_q[HB-1], min_q};
  assign num_full = {hc_q[HB-1], hc_q} - {min_q[HB-1], min_q};
  assign prod     = {num_full[HB-1:0], LB'(0)} - (HB+LB)'(num_full[HB-1:0]);
  assign chan_num = {n_q, 8'd0} - CNW'(n_q) + CNW'(HALF);

  // Channel divide by full scale through a reciprocal multiply, exact over chan_num
  assign chan_prod = PW'(chan_num) * PW'(RECIP);
  assign chan_quot = chan_prod[PW-1:RSH];

  // Restoring divider step, one quotient bit per cycle
  assign w_shift = w_q << 1;
  assign w_top   = w_shift[WW-1:QB];
  assign den_ext = RW'(den_q);

  always_comb begin
    w_d = w_shift;
    if (w_top >= den_ext) begin
      w_d[WW-1:QB] = w_top - den_ext;
      w_d[0]       = 1'b1;
    end
  end

  assign sts_o.div_last = (cnt_q == CW'(QB - 1));
  assign quot           = w_q[QB-1:0];

  // Ramp segment
  always_comb begin
    level_d = flat_q ? '0 : quot[LB-1:0];
    l4      = {level_d, 2'b00};
    priority if (l4 < FULL1) begin
      seg_d = SEG_BLUE_CYAN;
      n_d   = l4[LB-1:0];
    end else if (l4 < FULL2) begin
      seg_d = SEG_CYAN_GREEN;
      n_d   = LB'(FULL2 - l4);
    end else if (l4 < FULL3) begin
      seg_d = SEG_GREEN_YELLOW;
      n_d   = LB'(l4 - FULL2);
    end else begin
      seg_d = SEG_YELLOW_RED;
      n_d   = LB'(FULL4 - l4);
    end
  end

  assign chan = (chan_quot > (PW-RSH)'(255)) ? 8'hFF : chan_quot[7:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) height_q <= height_i;
    if (cmd_i.clamp) begin
      hc_q   <= hc_d;
      den_q  <= DNW'(den_full[HB-1:0]);
      flat_q <= empty_q | ~(max_q > min_q);
    end
    if (cmd_i.load_num) begin
      w_q <= WW'(prod);
    end else if (cmd_i.div_step) begin
      w_q <= w_d;
    end
    if (cmd_i.ramp) begin
      level_q <= level_d;
      n_q     <= n_d;
      seg_q   <= seg_d;
    end
    if (cmd_i.load_chan) chan_q <= chan;
    if (cmd_i.load_out) begin
      lvl_out_q  <= level_q;
      flat_out_q <= flat_q;
      unique case (seg_q)
        SEG_BLUE_CYAN: begin
          red_q <= 8'd0;   green_q <= chan_q; blue_q <= 8'hFF;
        end
        SEG_CYAN_GREEN: begin
          red_q <= 8'd0;   green_q <= 8'hFF;  blue_q <= chan_q;
        end
        SEG_GREEN_YELLOW: begin
          red_q <= chan_q; green_q <= 8'hFF;  blue_q <= 8'd0;
        end
        SEG_YELLOW_RED: begin
          red_q <= 8'hFF;  green_q <= chan_q; blue_q <= 8'd0;
        end
        default: begin
          red_q <= 8'd0;   green_q <= 8'd0;   blue_q <= 8'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load_num) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + CW'(1);
    end
  end

  assign red_o        = red_q;
  assign green_o      = green_q;
  assign blue_o       = blue_q;
  assign level_o      = lvl_out_q;
  assign flat_range_o = flat_out_q;

endmodule

### src/height_normalize_color_ramp.sv
// Top level: min/max height normalizer with blue-cyan-green-yellow-red color ramp.
// Op 0 beats extend the running min/max and op 2 beats clear it; neither gives a result.
// An op 1 beat clamps the height to the extents, normalizes it to a LEVEL_BITS level and
// maps it to RGB: a restoring divider yields one level bit per cycle, and the ramp channel
// then comes from a reciprocal multiply. Empty extents or max equal to min give level 0,
// flat_range 1 and pure blue. The result sits in an output register; the next beat is
// taken while it waits, and an op 1 beat stalls at its end until the register is free.
// Op code 3 is ignored.
module height_normalize_color_ramp #(
  parameter int HEIGHT_BITS = 16,
  parameter int LEVEL_BITS  = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hncr_in_if.sink    in_i,
  hncr_out_if.source out_o
);
  import hncr_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  hncr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_op_i     (in_i.op),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hncr_dp #(
    .HEIGHT_BITS (HEIGHT_BITS),
    .LEVEL_BITS  (LEVEL_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .op_i         (in_i.op),
    .height_i     (in_i.height),
    .red_o        (out_o.red),
    .green_o      (out_o.green),
    .blue_o       (out_o.blue),
    .level_o      (out_o.level),
    .flat_range_o (out_o.flat_range)
  );

endmodule

### tb/sv/hncr_color_checker.sv
// Checker for the height normalizer: tracks extents, predicts colors and compares beats.
module hncr_color_checker (
  input  logic clk_i,
  input  logic rst_ni,
  hncr_in_if   height_ch,
  hncr_out_if  color_ch,
  output int   mismatches_o,
  output int   pending_o,
  output int   checked_o,
  output int   flat_seen_o
);
  import hncr_pkg::*;

  localparam int LEVEL_BITS = 10;
  localparam longint FULL = (longint'(1) << LEVEL_BITS) - 1;

  typedef struct packed {
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic [LEVEL_BITS-1:0] level;
    logic                  flat_range;
  } color_t;

  logic signed [15:0] lo_h;
  logic signed [15:0] hi_h;
  logic               no_extents;
  color_t             expected_colors[$];

  task automatic report_mismatch(input string msg);
    $display("MISMATCH %s", msg);
    mismatches_o++;
  endtask

  function automatic logic [7:0] ramp_channel(input longint n);
    longint v;
    v = (255 * n + FULL / 2) / FULL;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic color_t predict_color(input logic signed [15:0] h);
    color_t c;
    longint hc;
    longint num;
    longint den;
    longint lvl;
    longint l4;
    lvl = 0;
    c.flat_range = 1'b1;
    if (!no_extents && hi_h > lo_h) begin
      hc = h;
      if (hc < lo_h) hc = lo_h;
      if (hc > hi_h) hc = hi_h;
      den = longint'(hi_h) - longint'(lo_h);
      num = hc - longint'(lo_h);
      lvl = (num * FULL) / den;
      if (lvl > FULL) lvl = FULL;
      c.flat_range = 1'b0;
    end
    l4 = lvl * 4;
    if (l4 < FULL) begin
      c.red = 8'd0;
      c.green = ramp_channel(l4);
      c.blue = 8'd255;
    end else if (l4 < 2 * FULL) begin
      c.red = 8'd0;
      c.green = 8'd255;
      c.blue = ramp_channel(2 * FULL - l4);
    end else if (l4 < 3 * FULL) begin
      c.red = ramp_channel(l4 - 2 * FULL);
      c.green = 8'd255;
      c.blue = 8'd0;
    end else begin
      c.red = 8'd255;
      c.green = ramp_channel(4 * FULL - l4);
      c.blue = 8'd0;
    end
    c.level = lvl[LEVEL_BITS-1:0];
    return c;
  endfunction

  initial begin
    mismatches_o = 0;
    pending_o = 0;
    checked_o = 0;
    flat_seen_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin : watch
    color_t want;
    if (!rst_ni) begin
      lo_h = '0;
      hi_h = '0;
      no_extents = 1'b1;
      expected_colors.delete();
    end else begin
      // result side first: a beat taken on this edge cannot come out on it
      if (color_ch.valid && color_ch.ready) begin
        if (expected_colors.size() == 0) begin
          report_mismatch($sformatf("unexpected color beat: level %0d", color_ch.level));
        end else begin
          want = expected_colors.pop_front();
          checked_o++;
          if (want.flat_range) flat_seen_o++;
          if (color_ch.red !== want.red)
            report_mismatch($sformatf("red: got %0d, expected %0d",
                                      color_ch.red, want.red));
          if (color_ch.green !== want.green)
            report_mismatch($sformatf("green: got %0d, expected %0d",
                                      color_ch.green, want.green));
          if (color_ch.blue !== want.blue)
            report_mismatch($sformatf("blue: got %0d, expected %0d",
                                      color_ch.blue, want.blue));
          if (color_ch.level !== want.level)
            report_mismatch($sformatf("level: got %0d, expected %0d",
                                      color_ch.level, want.level));
          if (color_ch.flat_range !== want.flat_range)
            report_mismatch($sformatf("flat_range: got %0d, expected %0d",
                                      color_ch.flat_range, want.flat_range));
        end
      end
      if (height_ch.valid && height_ch.ready) begin
        case (height_ch.op)
          OP_ACCUM: begin
            if (no_extents) begin
              lo_h = height_ch.height;
              hi_h = height_ch.height;
              no_extents = 1'b0;
            end else begin
              if (height_ch.height < lo_h) lo_h = height_ch.height;
              if (height_ch.height > hi_h) hi_h = height_ch.height;
            end
          end
          OP_MAP: expected_colors.insert(expected_colors.size(),
                                         predict_color(height_ch.height));
          OP_CLEAR: begin
            lo_h = '0;
            hi_h = '0;
            no_extents = 1'b1;
          end
          default: ;
        endcase
      end
    end
    pending_o = expected_colors.size();
  end

endmodule

### tb/sv/height_normalize_color_ramp_test.sv
// Top of the height normalizer testbench: clock, reset, height beats and color backpressure.
module height_normalize_color_ramp_test;
  import hncr_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_END = 1075;
  localparam int QUIET_FROM = 950;

  logic clk_i;
  logic rst_ni;
  logic beat_taken;
  bit   quiet;
  bit   gaps_on;
  bit   stalls_on;
  int   sent;
  int   cycles;
  int   mismatches;
  int   pending;
  int   checked;
  int   flat_seen;

  hncr_in_if #(.HEIGHT_BITS(16)) height_ch();
  hncr_out_if #(.LEVEL_BITS(10)) color_ch();

  height_normalize_color_ramp #(
    .HEIGHT_BITS(16),
    .LEVEL_BITS (10)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (height_ch),
    .out_o (color_ch)
  );

  hncr_color_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .height_ch   (height_ch),
    .color_ch    (color_ch),
    .mismatches_o(mismatches),
    .pending_o   (pending),
    .checked_o   (checked),
    .flat_seen_o (flat_seen)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_taken <= 1'b0;
    end else begin
      beat_taken <= height_ch.valid && height_ch.ready;
    end
  end

  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d colors still expected", cycles, pending);
      $display("height_normalize_color_ramp test failed");
      $finish;
    end
  end

  // color side backpressure
  initial begin : color_stall
    int stall_left;
    stall_left = 0;
    color_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 199) == 0) stalls_on = !stalls_on;
      if (!quiet && stalls_on && stall_left == 0 && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 15);
      color_ch.ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  task automatic send_beat(input logic [1:0] op, input logic signed [15:0] h);
    int gap;
    if (!quiet && gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      height_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    height_ch.valid <= 1'b1;
    height_ch.op <= op;
    height_ch.height <= h;
    do @(negedge clk_i); while (!beat_taken);
    sent++;
  endtask

  function automatic logic signed [15:0] pick_height(input int base, input int span);
    int v;
    v = base + int'($urandom_range(0, span));
    return v[15:0];
  endfunction

  initial begin : stimulus
    int base;
    int span;
    int n_acc;
    int n_map;
    int r;
    height_ch.valid = 1'b0;
    height_ch.op = OP_ACCUM;
    height_ch.height = '0;
    rst_ni = 1'b0;
    quiet = 1'b0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    sent = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty extents, single height, full range, op 3, clamping
    send_beat(OP_MAP, 16'sh7fff);
    send_beat(OP_ACCUM, 16'sd100);
    send_beat(OP_MAP, 16'sd100);
    send_beat(OP_MAP, -16'sd5);
    send_beat(OP_ACCUM, -16'sd32768);
    send_beat(OP_ACCUM, 16'sd32767);
    send_beat(OP_MAP, -16'sd32768);
    send_beat(OP_MAP, 16'sd32767);
    send_beat(OP_MAP, 16'sd0);
    send_beat(OP_MAP, -16'sd1);
    send_beat(OP_MAP, -16'sd16384);
    send_beat(OP_MAP, 16'sd16383);
    send_beat(OP_UNUSED, 16'sh5555);
    send_beat(OP_UNUSED, 16'shaaaa);
    send_beat(OP_MAP, 16'sd8191);
    send_beat(OP_CLEAR, 16'sd0);
    send_beat(OP_MAP, 16'sd5);
    send_beat(OP_ACCUM, -16'sd7);
    send_beat(OP_ACCUM, -16'sd7);
    send_beat(OP_MAP, -16'sd7);
    send_beat(OP_ACCUM, 16'sd9);
    send_beat(OP_MAP, -16'sd100);
    send_beat(OP_MAP, 16'sd100);
    send_beat(OP_MAP, 16'sd1);
    send_beat(OP_MAP, 16'sd2);

    while (sent < RANDOM_END) begin
      quiet = (sent >= QUIET_FROM);
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) != 0) send_beat(OP_CLEAR, 16'($urandom));
      base = int'($urandom_range(0, 65535)) - 32768;
      case ($urandom_range(0, 3))
        0: span = 65535;
        1: span = $urandom_range(1, 15);
        2: span = $urandom_range(16, 1023);
        default: span = $urandom_range(1024, 8191);
      endcase
      n_acc = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
      n_map = $urandom_range(4, 30);
      repeat (n_acc) send_beat(OP_ACCUM, pick_height(base, span));
      repeat (n_map) begin
        r = $urandom_range(0, 19);
        if (r == 0) send_beat(OP_UNUSED, 16'($urandom));
        else if (r == 1) send_beat(OP_ACCUM, pick_height(base, span));
        else if (r == 2) send_beat(OP_MAP, 16'($urandom));
        else send_beat(OP_MAP, pick_height(base - 2, span + 4));
      end
    end
    height_ch.valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);

    $display("sent %0d height beats with random gaps and color stalls", sent);
    $display("checked %0d colors, %0d of them on flat or empty extents", checked, flat_seen);
    if (mismatches == 0) begin
      $display("height_normalize_color_ramp test passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("height_normalize_color_ramp test failed");
    end
    $finish;
  end

endmodule
